/* design/ncc_template_match_macros.svh */
// Assertion macros shared by the matcher.
`ifndef NCC_TEMPLATE_MATCH_MACROS_SVH
`define NCC_TEMPLATE_MATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ncc_pkg.sv */
package ncc_pkg;

    localparam int TM      = 16;
    localparam int TDEPTH  = TM * TM;
    localparam int LINES   = TM - 1;
    localparam int IMW     = 1024;
    localparam int IMH     = 1024;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = $clog2(TM);
    localparam int PDIM_W  = 5;
    localparam int IDIM_W  = 11;
    localparam int CNT_W   = $clog2(TDEPTH + 1);
    localparam int TADDR_W = $clog2(TDEPTH);
    localparam int SUM_W   = PIX_W + TADDR_W;
    localparam int SQ_W    = 2 * PIX_W + TADDR_W;
    localparam int COL_W   = $clog2(IMW);
    localparam int POS_W   = 10;

    localparam int SCORE_W = 16;
    localparam int VAR_W   = SQ_W + CNT_W + 1;
    localparam int MB_W    = VAR_W / 2;
    localparam int PROD_W  = VAR_W + MB_W;
    localparam int BIG_W   = 2 * VAR_W;
    localparam int CMP_W   = 2 * VAR_W + 2 * SCORE_W;
    localparam int FRAC2   = 2 * (SCORE_W - 1);

    localparam logic OP_TEMPLATE = 1'b0;
    localparam logic OP_TARGET   = 1'b1;

    localparam logic [1:0] CFG_PAT_W = 2'd0;
    localparam logic [1:0] CFG_PAT_H = 2'd1;
    localparam logic [1:0] CFG_IMG_W = 2'd2;
    localparam logic [1:0] CFG_IMG_H = 2'd3;

    typedef logic [TM-1:0][PIX_W-1:0]    t_column;
    typedef logic [LINES-1:0][PIX_W-1:0] t_line;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sp;
        logic [SQ_W-1:0]  spp;
        logic [SUM_W-1:0] st;
        logic [SQ_W-1:0]  stt;
        logic [SQ_W-1:0]  spt;
    } t_score_in;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               flat;
        logic [SCORE_W-1:0] score;
    } t_score_out;

endpackage

/* design/ncc_cell.sv */
module ncc_cell (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  ncc_pkg::t_column             i_col,
    input  logic [ncc_pkg::DIM_W-1:0]    i_row_sel,
    output ncc_pkg::t_column             o_col,
    output logic [ncc_pkg::PIX_W-1:0]    o_pix
);
    import ncc_pkg::*;

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_pix = r_col[i_row_sel];

endmodule

/* design/ncc_score.sv */
module ncc_score (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ncc_pkg::t_score_in  i_in,
    output ncc_pkg::t_score_out o_out
);
    import ncc_pkg::*;

    typedef enum logic [3:0] {
        SC_IDLE, SC_M0, SC_M1, SC_M2, SC_M3, SC_M4, SC_M5, SC_M6,
        SC_M7, SC_M8, SC_M9, SC_M10, SC_ITER, SC_FIN
    } t_sc_state;

    t_sc_state           r_state;
    t_score_in           r_in;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_x;
    logic signed [VAR_W:0] r_vp;
    logic signed [VAR_W:0] r_vt;
    logic [VAR_W-1:0]    r_mag;
    logic                r_neg;
    logic [BIG_W-1:0]    r_p;
    logic [CMP_W-1:0]    r_r;
    logic [CMP_W-1:0]    r_a;
    logic [CMP_W-1:0]    r_b;
    logic [SCORE_W-1:0]  r_q;
    logic [3:0]          r_bit;
    logic                r_done;
    logic                r_flat;
    logic [SCORE_W-1:0]  r_score;

    logic [VAR_W-1:0]    m_a;
    logic [MB_W-1:0]     m_b;
    logic [PROD_W-1:0]   m_prod;
    logic signed [VAR_W:0] d_diff;
    logic [CMP_W-1:0]    c_cand;
    logic                c_take;
    logic                vp_pos;
    logic                vt_pos;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            SC_M0: begin
                m_a = VAR_W'(r_in.spp);
                m_b = MB_W'(r_in.n);
            end
            SC_M1: begin
                m_a = VAR_W'(r_in.sp);
                m_b = MB_W'(r_in.sp);
            end
            SC_M2: begin
                m_a = VAR_W'(r_in.stt);
                m_b = MB_W'(r_in.n);
            end
            SC_M3: begin
                m_a = VAR_W'(r_in.st);
                m_b = MB_W'(r_in.st);
            end
            SC_M4: begin
                m_a = VAR_W'(r_in.spt);
                m_b = MB_W'(r_in.n);
            end
            SC_M5: begin
                m_a = VAR_W'(r_in.sp);
                m_b = MB_W'(r_in.st);
            end
            SC_M6: begin
                m_a = r_vp[VAR_W-1:0];
                m_b = r_vt[MB_W-1:0];
            end
            SC_M7: begin
                m_a = r_vp[VAR_W-1:0];
                m_b = r_vt[VAR_W-1:MB_W];
            end
            SC_M8: begin
                m_a = r_mag;
                m_b = r_mag[MB_W-1:0];
            end
            SC_M9: begin
                m_a = r_mag;
                m_b = r_mag[VAR_W-1:MB_W];
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_prod = PROD_W'(m_a) * PROD_W'(m_b);
    assign d_diff = $signed({1'b0, r_x[VAR_W-1:0]}) - $signed({1'b0, r_prod[VAR_W-1:0]});
    assign vp_pos = !r_vp[VAR_W] && (r_vp != '0);
    assign vt_pos = !r_vt[VAR_W] && (r_vt != '0);

    assign c_cand = r_a + (r_b << ({1'b0, r_bit} + 5'd1))
                  + (CMP_W'(r_p) << {r_bit, 1'b0});
    assign c_take = !r_q[SCORE_W-1] && (c_cand <= r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_prod <= m_prod;
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_in    <= i_in;
                        r_state <= SC_M0;
                    end
                end
                SC_M0: r_state <= SC_M1;
                SC_M1: begin
                    r_x     <= r_prod;
                    r_state <= SC_M2;
                end
                SC_M2: begin
                    r_vp    <= d_diff;
                    r_state <= SC_M3;
                end
                SC_M3: begin
                    r_x     <= r_prod;
                    r_state <= SC_M4;
                end
                SC_M4: begin
                    r_vt    <= d_diff;
                    r_state <= SC_M5;
                end
                SC_M5: begin
                    r_x     <= r_prod;
                    r_state <= SC_M6;
                end
                SC_M6: begin
                    r_neg  <= d_diff[VAR_W];
                    r_mag  <= d_diff[VAR_W] ? VAR_W'(-d_diff) : d_diff[VAR_W-1:0];
                    r_flat <= !(vp_pos && vt_pos);
                    r_state <= (vp_pos && vt_pos) ? SC_M7 : SC_FIN;
                end
                SC_M7: begin
                    r_x     <= r_prod;
                    r_state <= SC_M8;
                end
                SC_M8: begin
                    r_p     <= BIG_W'(r_x) + (BIG_W'(r_prod) << MB_W);
                    r_state <= SC_M9;
                end
                SC_M9: begin
                    r_x     <= r_prod;
                    r_state <= SC_M10;
                end
                SC_M10: begin
                    r_r     <= (CMP_W'(r_x) + (CMP_W'(r_prod) << MB_W)) << FRAC2;
                    r_a     <= '0;
                    r_b     <= '0;
                    r_q     <= '0;
                    r_bit   <= 4'(SCORE_W - 1);
                    r_state <= SC_ITER;
                end
                SC_ITER: begin
                    if (c_take) begin
                        r_a        <= c_cand;
                        r_b        <= r_b + (CMP_W'(r_p) << r_bit);
                        r_q[r_bit] <= 1'b1;
                    end
                    if (r_bit == 4'd0) begin
                        r_state <= SC_FIN;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                SC_FIN: begin
                    if (r_flat) begin
                        r_score <= '0;
                    end else if (r_neg) begin
                        r_score <= SCORE_W'(0) - r_q;
                    end else if (r_q[SCORE_W-1]) begin
                        r_score <= {1'b0, {(SCORE_W-1){1'b1}}};
                    end else begin
                        r_score <= r_q;
                    end
                    r_done  <= 1'b1;
                    r_state <= SC_IDLE;
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_out.busy  = (r_state != SC_IDLE);
    assign o_out.done  = r_done;
    assign o_out.flat  = r_flat;
    assign o_out.score = r_score;

endmodule

/* design/ncc_template_match.sv */
// Template matcher with zero-mean normalized cross-correlation.
// The input channel (valid/ready) carries an op bit and an 8-bit pixel. Items with op 0
// load the template in raster order; items with op 1 are target pixels in raster order.
// For each target pixel that closes a full window with a complete template, one item
// leaves on the output channel (valid/ready) with a signed Q1.15 score, the window's
// top-left position, a flat flag and a frame end flag. The plain write port sets
// template and image size and must be written only while the block is idle; the block
// does not enforce this. A template pixel is stored as it is taken, and the block
// stays ready. A target pixel that closes no window goes through a row line read, then
// a window shift. A target pixel that closes a window runs one multiply-accumulate per
// template pixel through the window, then a shared 34x17 multiplier and a 16-step
// bit-serial root search, skipped when the template or window is flat, form the score.
// The result sits in an output register, so the next item is taken while it waits;
// only a second score finished before the first is taken holds the block.
// Reset is synchronous and active low; it restores the default sizes and clears the
// template sums and position counters. The line and template memories are not cleared.
`include "ncc_template_match_macros.svh"

module ncc_template_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [ncc_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [ncc_pkg::SCORE_W-1:0] o_score,
    output logic [ncc_pkg::POS_W-1:0]      o_pos_x,
    output logic [ncc_pkg::POS_W-1:0]      o_pos_y,
    output logic                           o_flat,
    output logic                           o_frame_end,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [ncc_pkg::IDIM_W-1:0]     i_cfg_data
);
    import ncc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MAC, S_FLUSH, S_START, S_SCORE, S_PUT
    } t_state;

    t_state              r_state;
    logic [PDIM_W-1:0]   r_pat_w;
    logic [PDIM_W-1:0]   r_pat_h;
    logic [IDIM_W-1:0]   r_img_w;
    logic [IDIM_W-1:0]   r_img_h;
    logic [CNT_W-1:0]    r_tcount;
    logic [SUM_W-1:0]    r_tsum;
    logic [SQ_W-1:0]     r_tsq;
    logic [COL_W-1:0]    r_colc;
    logic [COL_W-1:0]    r_rowc;
    logic [COL_W-1:0]    r_cur_col;
    logic [PIX_W-1:0]    r_px;
    logic                r_emit;
    logic [POS_W-1:0]    r_pos_x;
    logic [POS_W-1:0]    r_pos_y;
    logic                r_fe;
    logic [PDIM_W-1:0]   r_dx;
    logic [PDIM_W-1:0]   r_dy;
    logic [TADDR_W-1:0]  r_taddr;
    logic                r_ov;
    logic signed [SCORE_W-1:0] r_score;
    logic [POS_W-1:0]    r_out_x;
    logic [POS_W-1:0]    r_out_y;
    logic                r_out_flat;
    logic                r_out_fe;

    logic [PIX_W-1:0]    r_tmem [TDEPTH];
    t_line               r_rmem [IMW];
    t_line               r_line;
    logic [PIX_W-1:0]    r_tv;
    logic [PIX_W-1:0]    r_pv;
    logic                r_iv;
    logic [SUM_W-1:0]    r_st;
    logic [SQ_W-1:0]     r_stt;
    logic [SQ_W-1:0]     r_spt;

    logic [PDIM_W-1:0]   pw;
    logic [PDIM_W-1:0]   ph;
    logic [IDIM_W-1:0]   iw;
    logic [IDIM_W-1:0]   ih;
    logic [CNT_W-1:0]    n;
    logic                tpl_full;
    logic [IDIM_W-1:0]   c_col;
    logic [IDIM_W-1:0]   c_row;
    logic [IDIM_W-1:0]   c_row_a;
    logic [IDIM_W-1:0]   n_col;
    logic [IDIM_W-1:0]   n_row;
    logic [IDIM_W-1:0]   n_row_a;
    logic                c_emit;
    logic                acc_op0;
    logic                acc_op1;
    logic                mac_last;
    logic [DIM_W:0]      cidx_w;
    logic [DIM_W-1:0]    cidx;
    logic [DIM_W-1:0]    ridx;
    logic                out_load;
    t_column             new_col;
    t_column             w_link [1:TM-1];
    logic [PIX_W-1:0]    w_pix [TM];
    t_score_in           sc_in;
    t_score_out          sc_out;

    assign pw = (r_pat_w == '0) ? PDIM_W'(1) : ((r_pat_w > PDIM_W'(TM)) ? PDIM_W'(TM) : r_pat_w);
    assign ph = (r_pat_h == '0) ? PDIM_W'(1) : ((r_pat_h > PDIM_W'(TM)) ? PDIM_W'(TM) : r_pat_h);
    assign iw = (r_img_w == '0) ? IDIM_W'(1) : ((r_img_w > IDIM_W'(IMW)) ? IDIM_W'(IMW) : r_img_w);
    assign ih = (r_img_h == '0) ? IDIM_W'(1) : ((r_img_h > IDIM_W'(IMH)) ? IDIM_W'(IMH) : r_img_h);
    assign n  = CNT_W'(pw) * CNT_W'(ph);
    assign tpl_full = (r_tcount >= n);

    assign o_in_ready = (r_state == S_IDLE);
    assign acc_op0 = i_in_valid && o_in_ready && (i_op == OP_TEMPLATE);
    assign acc_op1 = i_in_valid && o_in_ready && (i_op == OP_TARGET);

    always_comb begin
        if ({1'b0, r_colc} >= iw) begin
            c_col   = '0;
            c_row_a = {1'b0, r_rowc} + IDIM_W'(1);
        end else begin
            c_col   = {1'b0, r_colc};
            c_row_a = {1'b0, r_rowc};
        end
        c_row = (c_row_a >= ih) ? '0 : c_row_a;
        n_col = c_col + IDIM_W'(1);
        n_row_a = c_row;
        if (n_col >= iw) begin
            n_col   = '0;
            n_row_a = c_row + IDIM_W'(1);
        end
        n_row = (n_row_a >= ih) ? '0 : n_row_a;
    end

    assign c_emit = tpl_full && (c_col + IDIM_W'(1) >= IDIM_W'(pw))
                  && (c_row + IDIM_W'(1) >= IDIM_W'(ph));

    assign mac_last = (r_dx == pw - PDIM_W'(1)) && (r_dy == ph - PDIM_W'(1));
    assign cidx_w   = (DIM_W + 1)'(TM) - (DIM_W + 1)'(pw) + (DIM_W + 1)'(r_dx);
    assign cidx     = cidx_w[DIM_W-1:0];
    assign ridx     = DIM_W'(ph - PDIM_W'(1) - r_dy);

    assign out_load = ((r_state == S_SCORE && sc_out.done) || r_state == S_PUT)
                    && (!r_ov || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pat_w  <= PDIM_W'(16);
            r_pat_h  <= PDIM_W'(16);
            r_img_w  <= IDIM_W'(1024);
            r_img_h  <= IDIM_W'(1024);
            r_tcount <= '0;
            r_tsum   <= '0;
            r_tsq    <= '0;
            r_colc   <= '0;
            r_rowc   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAT_W: r_pat_w <= i_cfg_data[PDIM_W-1:0];
                    CFG_PAT_H: r_pat_h <= i_cfg_data[PDIM_W-1:0];
                    CFG_IMG_W: r_img_w <= i_cfg_data;
                    CFG_IMG_H: r_img_h <= i_cfg_data;
                    default:   r_img_h <= r_img_h;
                endcase
            end

            if (out_load) begin
                r_ov       <= 1'b1;
                r_score    <= sc_out.score;
                r_out_flat <= sc_out.flat;
                r_out_x    <= r_pos_x;
                r_out_y    <= r_pos_y;
                r_out_fe   <= r_fe;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (acc_op0) begin
                        if (tpl_full) begin
                            r_tcount <= CNT_W'(1);
                            r_tsum   <= SUM_W'(i_pixel);
                            r_tsq    <= SQ_W'(i_pixel) * SQ_W'(i_pixel);
                        end else begin
                            r_tcount <= r_tcount + CNT_W'(1);
                            r_tsum   <= r_tsum + SUM_W'(i_pixel);
                            r_tsq    <= r_tsq + SQ_W'(i_pixel) * SQ_W'(i_pixel);
                        end
                        r_colc <= '0;
                        r_rowc <= '0;
                    end else if (acc_op1) begin
                        r_px      <= i_pixel;
                        r_cur_col <= c_col[COL_W-1:0];
                        r_emit    <= c_emit;
                        r_pos_x   <= POS_W'(c_col + IDIM_W'(1) - IDIM_W'(pw));
                        r_pos_y   <= POS_W'(c_row + IDIM_W'(1) - IDIM_W'(ph));
                        r_fe      <= (c_col + IDIM_W'(1) == iw) && (c_row + IDIM_W'(1) == ih);
                        r_colc    <= n_col[COL_W-1:0];
                        r_rowc    <= n_row[COL_W-1:0];
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_dx    <= '0;
                    r_dy    <= '0;
                    r_taddr <= '0;
                    r_state <= r_emit ? S_MAC : S_IDLE;
                end
                S_MAC: begin
                    r_taddr <= r_taddr + TADDR_W'(1);
                    if (r_dx == pw - PDIM_W'(1)) begin
                        r_dx <= '0;
                        r_dy <= r_dy + PDIM_W'(1);
                    end else begin
                        r_dx <= r_dx + PDIM_W'(1);
                    end
                    if (mac_last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: r_state <= S_START;
                S_START: r_state <= S_SCORE;
                S_SCORE: begin
                    if (sc_out.done) begin
                        r_state <= out_load ? S_IDLE : S_PUT;
                    end
                end
                S_PUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_op0) begin
            r_tmem[tpl_full ? TADDR_W'(0) : TADDR_W'(r_tcount)] <= i_pixel;
        end
        r_pv <= r_tmem[r_taddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_op1) begin
            r_line <= r_rmem[c_col[COL_W-1:0]];
        end
        if (r_state == S_LOAD) begin
            r_rmem[r_cur_col] <= {r_line[LINES-2:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= (r_state == S_MAC);
        end
        r_tv <= w_pix[cidx];
        if (r_state == S_LOAD) begin
            r_st  <= '0;
            r_stt <= '0;
            r_spt <= '0;
        end else if (r_iv) begin
            r_st  <= r_st + SUM_W'(r_tv);
            r_stt <= r_stt + SQ_W'(r_tv) * SQ_W'(r_tv);
            r_spt <= r_spt + SQ_W'(r_tv) * SQ_W'(r_pv);
        end
    end

    assign new_col = {r_line, r_px};

    for (genvar g = 0; g < TM; g++) begin : g_cell
        if (g == 0) begin : g_first
            ncc_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (r_state == S_LOAD),
                .i_col     (w_link[1]),
                .i_row_sel (ridx),
                .o_col     (),
                .o_pix     (w_pix[g])
            );
        end else if (g == TM - 1) begin : g_last
            ncc_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (r_state == S_LOAD),
                .i_col     (new_col),
                .i_row_sel (ridx),
                .o_col     (w_link[g]),
                .o_pix     (w_pix[g])
            );
        end else begin : g_mid
            ncc_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (r_state == S_LOAD),
                .i_col     (w_link[g+1]),
                .i_row_sel (ridx),
                .o_col     (w_link[g]),
                .o_pix     (w_pix[g])
            );
        end
    end

    assign sc_in.n   = n;
    assign sc_in.sp  = r_tsum;
    assign sc_in.spp = r_tsq;
    assign sc_in.st  = r_st;
    assign sc_in.stt = r_stt;
    assign sc_in.spt = r_spt;

    ncc_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_in    (sc_in),
        .o_out   (sc_out)
    );

    assign o_out_valid = r_ov;
    assign o_score     = r_score;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_flat      = r_out_flat;
    assign o_frame_end = r_out_fe;

    `NCC_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, o_in_ready, !sc_out.busy, "Input taken while the score unit is busy.")
    `NCC_ASSERT_NOW(a_load_free, i_clk, i_rst_n, out_load, (!r_ov || i_out_ready), "Output register overwritten before it was taken.")
    `NCC_ASSERT_NEXT(a_mac_end, i_clk, i_rst_n, (r_state == S_MAC) && mac_last, r_state == S_FLUSH, "Window walk did not end after the last pixel.")
    `NCC_ASSERT_NOW(a_tcount_max, i_clk, i_rst_n, 1'b1, r_tcount <= CNT_W'(TDEPTH), "Template count beyond the template store.")

endmodule

/* sim/tb_ncc_template_match.sv */
module tb_ncc_template_match;
    import ncc_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] pixel;
    } t_pixel_item;

    typedef struct {
        logic signed [15:0] score;
        logic [9:0]         pos_x;
        logic [9:0]         pos_y;
        logic               flat;
        logic               frame_end;
    } t_match;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_op = OP_TEMPLATE;
    logic [PIX_W-1:0]    i_pixel = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [SCORE_W-1:0] o_score;
    logic [POS_W-1:0]    o_pos_x;
    logic [POS_W-1:0]    o_pos_y;
    logic                o_flat;
    logic                o_frame_end;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = CFG_PAT_W;
    logic [IDIM_W-1:0]   i_cfg_data = '0;

    ncc_template_match u_top (.*);

    always #10 i_clk = ~i_clk;

    t_pixel_item pixel_feed[$];
    t_match      match_queue[$];
    logic        in_took = 1'b0;
    int          accepted_items = 0;
    int          score_count = 0;
    int          flat_count = 0;
    int          frame_count = 0;
    int          fail_count = 0;

    // Shadow of the matcher state.
    logic [4:0]  reg_pat_w, reg_pat_h;
    logic [10:0] reg_img_w, reg_img_h;
    logic [7:0]  tmpl_mem[TDEPTH];
    logic [7:0]  line_mem[IMW*LINES];
    logic [7:0]  win[TM][TM];
    longint      tmpl_sum, tmpl_sq_sum;
    int          tmpl_count, col_cnt, row_cnt;

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void ncc_value(longint n, longint sp, longint spp, longint st,
                                      longint stt, longint spt,
                                      output logic [15:0] score, output logic flat);
        longint      vp, vt, num, mag;
        logic [127:0] prod, rhs, lhs;
        int unsigned q, t;
        vp = n * spp - sp * sp;
        vt = n * stt - st * st;
        num = n * spt - sp * st;
        q = 0;
        if (vp <= 0 || vt <= 0) begin
            score = '0;
            flat = 1'b1;
            return;
        end
        prod = {64'b0, vp} * {64'b0, vt};
        mag = (num < 0) ? -num : num;
        rhs = ({64'b0, mag} * {64'b0, mag}) << 30;
        for (int b = 15; b >= 0; b--) begin
            t = q | (32'd1 << b);
            if (t > 32768) continue;
            lhs = prod * {96'b0, t * t};
            if (lhs <= rhs) q = t;
        end
        flat = 1'b0;
        if (num >= 0) score = (q > 32767) ? 16'd32767 : q[15:0];
        else score = 16'(32'h10000 - q);
    endfunction

    task automatic predict_pixel(input logic op, input logic [7:0] px);
        int     pw, ph, iw, ih, n, col, row, base;
        longint st, stt, spt, tv, pv;
        t_match m;
        pw = clamp_dim(reg_pat_w, TM);
        ph = clamp_dim(reg_pat_h, TM);
        iw = clamp_dim(reg_img_w, IMW);
        ih = clamp_dim(reg_img_h, IMH);
        n = pw * ph;
        if (op == OP_TEMPLATE) begin
            if (tmpl_count >= n) begin
                tmpl_count = 0;
                tmpl_sum = 0;
                tmpl_sq_sum = 0;
            end
            tmpl_mem[tmpl_count] = px;
            tmpl_count++;
            tmpl_sum += px;
            tmpl_sq_sum += px * px;
            col_cnt = 0;
            row_cnt = 0;
            return;
        end
        if (col_cnt >= iw) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= ih) row_cnt = 0;
        col = col_cnt;
        row = row_cnt;
        for (int c = 0; c < TM - 1; c++)
            for (int k = 0; k < TM; k++) win[c][k] = win[c+1][k];
        base = col * LINES;
        win[TM-1][0] = px;
        for (int k = 0; k < LINES; k++) win[TM-1][k+1] = line_mem[base+k];
        for (int k = LINES - 1; k > 0; k--) line_mem[base+k] = line_mem[base+k-1];
        line_mem[base] = px;
        if (tmpl_count >= n && col + 1 >= pw && row + 1 >= ph) begin
            st = 0;
            stt = 0;
            spt = 0;
            for (int dy = 0; dy < ph; dy++) begin
                for (int dx = 0; dx < pw; dx++) begin
                    tv = win[TM-pw+dx][ph-1-dy];
                    pv = tmpl_mem[dy*pw+dx];
                    st += tv;
                    stt += tv * tv;
                    spt += tv * pv;
                end
            end
            ncc_value(n, tmpl_sum, tmpl_sq_sum, st, stt, spt, m.score, m.flat);
            m.pos_x = 10'(col + 1 - pw);
            m.pos_y = 10'(row + 1 - ph);
            m.frame_end = (col + 1 == iw && row + 1 == ih);
            match_queue.push_back(m);
        end
        col_cnt++;
        if (col_cnt >= iw) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= ih) row_cnt = 0;
        end
    endtask

    // Idling pattern rotates every hundred accepted items.
    function automatic bit sender_idle();
        case ((accepted_items / 100) % 4)
            1: return $urandom_range(99) < 87;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case ((accepted_items / 100) % 4)
            2: return $urandom_range(99) < 87;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        t_pixel_item it;
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                if (pixel_feed.size() > 0 && !sender_idle()) begin
                    it = pixel_feed.pop_front();
                    i_op <= it.op;
                    i_pixel <= it.pixel;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !receiver_stall();
        end
    end

    always @(posedge i_clk) begin
        t_match m;
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (match_queue.size() == 0) begin
                $display("%0t: unexpected score %0d at (%0d,%0d)", $time, o_score,
                         o_pos_x, o_pos_y);
                fail_count++;
            end else begin
                m = match_queue.pop_front();
                score_count++;
                flat_count += m.flat;
                frame_count += m.frame_end;
                if (o_score !== m.score || o_pos_x !== m.pos_x || o_pos_y !== m.pos_y ||
                    o_flat !== m.flat || o_frame_end !== m.frame_end) begin
                    $display({"%0t: expected score %0d pos (%0d,%0d) flat %0b end %0b, ",
                              "got %0d (%0d,%0d) %0b %0b"},
                             $time, m.score, m.pos_x, m.pos_y, m.flat, m.frame_end,
                             o_score, o_pos_x, o_pos_y, o_flat, o_frame_end);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_pixel(i_op, i_pixel);
            accepted_items++;
        end
    end

    task automatic drain();
        while (pixel_feed.size() > 0 || i_in_valid || match_queue.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_PAT_W: reg_pat_w = value[4:0];
            CFG_PAT_H: reg_pat_h = value[4:0];
            CFG_IMG_W: reg_img_w = value;
            default:   reg_img_h = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_sizes(input logic [10:0] pw, ph, iw, ih);
        write_reg(CFG_PAT_W, pw);
        write_reg(CFG_PAT_H, ph);
        write_reg(CFG_IMG_W, iw);
        write_reg(CFG_IMG_H, ih);
    endtask

    task automatic push_pixel(input logic op, input logic [7:0] px);
        t_pixel_item it;
        it.op = op;
        it.pixel = px;
        pixel_feed.push_back(it);
    endtask

    // Content styles: 0 full range, 1 constant, 2 two-level.
    function automatic logic [7:0] pick_pixel(int style, logic [7:0] level);
        case (style)
            1: return level;
            2: return $urandom_range(1) ? level : ~level;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial begin
        int pw, ph, iw, ih, n, frame, tstyle, istyle, tcount;
        logic [7:0] level;
        reg_pat_w = 5'd16;
        reg_pat_h = 5'd16;
        reg_img_w = 11'd1024;
        reg_img_h = 11'd1024;
        for (int i = 0; i < TDEPTH; i++) tmpl_mem[i] = '0;
        for (int i = 0; i < IMW * LINES; i++) line_mem[i] = '0;
        for (int c = 0; c < TM; c++)
            for (int k = 0; k < TM; k++) win[c][k] = '0;
        tmpl_sum = 0;
        tmpl_sq_sum = 0;
        tmpl_count = 0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, incomplete template, new template, flat cases.
        set_sizes(11'd3, 11'd2, 11'd5, 11'd3);
        push_pixel(OP_TEMPLATE, 8'd0);
        push_pixel(OP_TEMPLATE, 8'd255);
        push_pixel(OP_TEMPLATE, 8'd0);
        push_pixel(OP_TARGET, 8'd255);
        push_pixel(OP_TARGET, 8'd0);
        push_pixel(OP_TEMPLATE, 8'd255);
        push_pixel(OP_TEMPLATE, 8'd17);
        push_pixel(OP_TEMPLATE, 8'd200);
        for (int i = 0; i < 8; i++) push_pixel(OP_TARGET, (i % 3 == 0) ? 8'd255 : 8'd0);
        for (int i = 0; i < 7; i++) push_pixel(OP_TARGET, 8'd9);
        for (int i = 0; i < 6; i++) push_pixel(OP_TEMPLATE, 8'd7);
        for (int i = 0; i < 8; i++) push_pixel(OP_TARGET, 8'($urandom_range(255)));
        drain();

        // Register extremes: tallest template on a one-pixel-wide image.
        set_sizes(11'd0, 11'h7FF, 11'd0, 11'h7FF);
        for (int i = 0; i < 16; i++) push_pixel(OP_TEMPLATE, 8'($urandom_range(255)));
        for (int i = 0; i < 530; i++) push_pixel(OP_TARGET, 8'($urandom_range(255)));
        drain();

        // One-pixel template (the width field truncates to zero) on the widest image.
        set_sizes(11'h7E0, 11'd1, 11'd1024, 11'd0);
        for (int i = 0; i < 16; i++) push_pixel(OP_TEMPLATE, 8'($urandom_range(255)));
        for (int i = 0; i < 530; i++) push_pixel(OP_TARGET, 8'($urandom_range(255)));
        drain();

        // Template larger than the image.
        set_sizes(11'd4, 11'd3, 11'd3, 11'd2);
        for (int i = 0; i < 12; i++) push_pixel(OP_TEMPLATE, 8'($urandom_range(255)));
        for (int i = 0; i < 12; i++) push_pixel(OP_TARGET, 8'($urandom_range(255)));
        drain();

        while (accepted_items < 1550) begin
            pw = $urandom_range(1, 5);
            ph = $urandom_range(1, 4);
            iw = $urandom_range(1, 10) == 1 ? pw - 1 : pw + $urandom_range(0, 4);
            ih = ph + $urandom_range(0, 3);
            set_sizes(11'(pw), 11'(ph), 11'(clamp_dim(iw, IMW)), 11'(ih));
            pw = clamp_dim(pw, TM);
            ph = clamp_dim(ph, TM);
            iw = clamp_dim(iw, IMW);
            n = pw * ph;
            tstyle = $urandom_range(9) == 0 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
            istyle = $urandom_range(5) == 0 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
            level = $urandom_range(255);
            tcount = $urandom_range(5) == 0 ? $urandom_range(1, n) : n;
            for (int i = 0; i < tcount; i++)
                push_pixel(OP_TEMPLATE, pick_pixel(tstyle, level));
            frame = $urandom_range(1, 2);
            for (int i = 0; i < frame * iw * ih + $urandom_range(0, iw); i++) begin
                if ($urandom_range(49) == 0)
                    push_pixel(OP_TEMPLATE, pick_pixel(tstyle, level));
                else
                    push_pixel(OP_TARGET, pick_pixel(istyle, level));
            end
            if (tcount < n) begin
                for (int i = tcount; i < n; i++)
                    push_pixel(OP_TEMPLATE, pick_pixel(tstyle, level));
                for (int i = 0; i < iw * ih; i++)
                    push_pixel(OP_TARGET, pick_pixel(istyle, level));
            end
            drain();
        end

        $display("Run covered %0d items and %0d scores, %0d flat, %0d frame ends.",
                 accepted_items, score_count, flat_count, frame_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* ncc_template_match.f */
+incdir+design
design/ncc_pkg.sv
design/ncc_cell.sv
design/ncc_score.sv
design/ncc_template_match.sv
sim/tb_ncc_template_match.sv
